// ===== rtl/header_length_tail_deframer_top_assert.svh =====
// ----------------------------------------------------------------------------
// header_length_tail_deframer_top_assert.svh - assertion macros
// Shared concurrent assertion shorthands for the deframer, clocked on clock
// and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef HEADER_LENGTH_TAIL_DEFRAMER_TOP_ASSERT_SVH
`define HEADER_LENGTH_TAIL_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define HLTD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HLTD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/hltd_pkg.sv =====
// ----------------------------------------------------------------------------
// hltd_pkg - deframer package
// Widths, phase codes, result kinds and register indexes of the deframer.
// ----------------------------------------------------------------------------
package hltd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned PHASE_W = 17;
   localparam int unsigned SYNC_W  = 32;
   localparam int unsigned CSR_IDX_W = 2;

   // phase codes up to the start of the frame body
   localparam logic [PHASE_W-1:0] PH_HUNT0   = 17'd0;
   localparam logic [PHASE_W-1:0] PH_HUNT3   = 17'd3;
   localparam logic [PHASE_W-1:0] PH_SIZE_LO = 17'd4;
   localparam logic [PHASE_W-1:0] PH_SIZE_HI = 17'd5;
   localparam logic [PHASE_W-1:0] PH_BODY    = 17'd6;

   // tail sits at phase frame_size + this
   localparam logic [PHASE_W-1:0] TAIL_OFFSET = 17'd5;

   localparam logic [LEN_W-1:0] INFO_LIMIT_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      KIND_INFO    = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_BADTAIL = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_WORD  = 2'd0,
      CSR_TAIL_VALUE = 2'd1,
      CSR_INFO_LIMIT = 2'd2,
      CSR_HEAD_INFO  = 2'd3
   } csr_index_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  len;
   } result_type;

endpackage

// ===== rtl/header_length_tail_deframer_top.sv =====
// ----------------------------------------------------------------------------
// header_length_tail_deframer_top - sync header / length / tail deframer
// Hunts a four-byte sync header, reads a little-endian frame size, forwards
// the body bytes and reports accept or drop at the tail byte.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_stall req_rx_byte
//   rsp_      out        rsp_valid/rsp_stall rsp_out_kind, rsp_out_byte,
//                                            rsp_payload_len
//   csr_      in         csr_valid/csr_ready csr_index, csr_data
//
// one request per cycle sustained while req_stall is low; a request is
// registered, then the frame state and its result update while the skid
// entry is free, the result going to the output register, else to the skid entry
// the output register is backed by one skid entry; the input stalls only
// while that skid entry is occupied and a byte waits in the input register
// reset (synchronous, active high) clears the hunt state, the pipeline valids
// and the registers to their defaults; csr writes are always taken
//
module header_length_tail_deframer_top
   import hltd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_out_kind,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic [LEN_W-1:0]     rsp_payload_len,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SYNC_W-1:0]    csr_data
);

   // configuration registers
   logic [SYNC_W-1:0] sync_word_ff;
   logic [BYTE_W-1:0] tail_value_ff;
   logic [LEN_W-1:0]  info_limit_ff;
   logic [LEN_W-1:0]  head_info_ff;

   // input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // frame state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [LEN_W-1:0]   frame_size_ff, frame_size_in;

   // output register and skid entry
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;

   // step logic
   logic               advance;
   logic               res_valid;
   result_type         res_data;
   logic [BYTE_W-1:0]  want_byte;
   logic [LEN_W-1:0]   size_full;
   logic [PHASE_W:0]   hi_bound;
   logic [PHASE_W-1:0] lo_bound;
   logic [PHASE_W-1:0] tail_phase;
   logic               rsp_take;
   logic               rsp_hold;

   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff  <= '0;
         tail_value_ff <= '0;
         info_limit_ff <= INFO_LIMIT_RESET;
         head_info_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SYNC_WORD:  sync_word_ff  <= csr_data;
            CSR_TAIL_VALUE: tail_value_ff <= csr_data[BYTE_W-1:0];
            CSR_INFO_LIMIT: info_limit_ff <= csr_data[LEN_W-1:0];
            CSR_HEAD_INFO:  head_info_ff  <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- input stage
   // the skid entry being free means the result of the registered byte always
   // has a place to go
   assign advance   = in_valid_ff && !skid_valid_ff;
   assign req_stall = in_valid_ff && skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // ---------------------------------------------------------------- frame step
   assign want_byte  = sync_word_ff[BYTE_W*phase_ff[1:0] +: BYTE_W];
   assign size_full  = {in_byte_ff, frame_size_ff[BYTE_W-1:0]};
   // bounds kept wider than the size fields so the sums never wrap
   assign hi_bound   = {2'b00, info_limit_ff} + {2'b00, head_info_ff} + 18'd1;
   assign lo_bound   = {1'b0, head_info_ff} + 17'd1;
   assign tail_phase = {1'b0, frame_size_ff} + TAIL_OFFSET;

   always_comb begin
      phase_in      = phase_ff;
      frame_size_in = frame_size_ff;
      res_valid     = 1'b0;
      res_data.kind = KIND_INFO;
      res_data.data = in_byte_ff;
      res_data.len  = '0;
      if (advance) begin
         if (phase_ff <= PH_HUNT3) begin
            // a mismatching byte is consumed, not retried as a first byte
            phase_in = (in_byte_ff == want_byte) ? phase_ff + 17'd1 : PH_HUNT0;
         end else if (phase_ff == PH_SIZE_LO) begin
            frame_size_in = {{(LEN_W-BYTE_W){1'b0}}, in_byte_ff};
            phase_in      = PH_SIZE_HI;
         end else if (phase_ff == PH_SIZE_HI) begin
            frame_size_in = size_full;
            if (({2'b00, size_full} > hi_bound) || ({1'b0, size_full} < lo_bound)) begin
               phase_in = PH_HUNT0;
            end else begin
               phase_in = PH_BODY;
            end
         end else if (phase_ff >= tail_phase) begin
            // tail byte: accept or drop, then hunt again
            phase_in  = PH_HUNT0;
            res_valid = 1'b1;
            if (in_byte_ff == tail_value_ff) begin
               res_data.kind = KIND_ACCEPT;
               res_data.len  = frame_size_ff - 16'd1 - head_info_ff;
            end else begin
               res_data.kind = KIND_BADTAIL;
            end
         end else begin
            phase_in  = phase_ff + 17'd1;
            res_valid = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT0;
         frame_size_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         frame_size_ff <= frame_size_in;
      end
   end

   // ---------------------------------------------------------------- output buffer
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign rsp_hold = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no new result can arrive while the skid entry is full
         if (rsp_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_take) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res_data;
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_kind    = rsp_data_ff.kind;
   assign rsp_out_byte    = rsp_data_ff.data;
   assign rsp_payload_len = rsp_data_ff.len;

   // ---------------------------------------------------------------- assertions
`include "header_length_tail_deframer_top_assert.svh"

   // skid entry only holds a result behind a full output register
   `HLTD_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, rsp_valid_ff, "skid without output")

   // a stalled result stays put
   `HLTD_ASSERT_NEXT(a_rsp_hold, rsp_hold, rsp_valid_ff && $stable(rsp_data_ff), "held result lost")

   // skid entry only fills while the output is blocked
   `HLTD_ASSERT_NEXT(a_skid_needs_stall, !skid_valid_ff && !rsp_hold, !skid_valid_ff, "skid fill")

   // body counting never runs past the tail position
   `HLTD_ASSERT_NOW(a_phase_in_frame, phase_ff >= PH_BODY, phase_ff <= tail_phase, "phase past tail")

endmodule
